>>> src/cl3_pkg.sv
// ----------------------------------------------------------------------------
// cl3_pkg
// Shared types, constants and helpers for the 3x3 convolution filter.
// ----------------------------------------------------------------------------
package cl3_pkg;

	// default frame size limits
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// field and register widths
	localparam int PIX_W      = 8;
	localparam int POS_W      = 10;
	localparam int CFG_SIZE_W = 11;
	localparam int ROW_REG_W  = 24;
	localparam int TAPS       = 3;

	// reset frame size
	localparam int WIDTH_RST  = 640;
	localparam int HEIGHT_RST = 480;
	localparam int MIN_SIZE   = 3;

	// arithmetic widths: 9-bit signed pixel times 8-bit tap, three per row
	localparam int PROD_W    = 17;
	localparam int ROW_SUM_W = 18;
	localparam int SUM_W     = 20;

	// fixed Laplacian taps
	localparam int LAP_CENTER = 4;
	localparam int LAP_EDGE   = -1;

	// output scale sum*128/400 reduces to sum*8/25
	localparam int SCALE_NUM   = 128;
	localparam int SCALE_DEN   = 400;
	localparam int SCALE_GCD   = 16;
	localparam int SCALE_MUL   = SCALE_NUM / SCALE_GCD;
	localparam int SCALE_DIV   = SCALE_DEN / SCALE_GCD;
	localparam int OUT_OFFSET  = 127;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_MUL   = (1 << RECIP_SHIFT) / SCALE_DIV;
	localparam int RECIP_W     = 20;
	localparam int MAG_W       = 22;
	localparam int QUO_W       = MAG_W + RECIP_W - RECIP_SHIFT;

	// register map
	typedef enum logic [2:0] {
		REG_KERNEL_MODE   = 3'd0,
		REG_KERNEL_TOP    = 3'd1,
		REG_KERNEL_MIDDLE = 3'd2,
		REG_KERNEL_BOTTOM = 3'd3,
		REG_IMAGE_WIDTH   = 3'd4,
		REG_IMAGE_HEIGHT  = 3'd5
	} reg_idx_t;

	typedef logic signed [7:0] coef_t;
	typedef coef_t [TAPS-1:0] coef_row_t;

	// line store strobes
	typedef struct packed {
		logic rd;      // transaction accepted: read both stores, write middle
		logic wr_top;  // item in stage 1 moves on: write top store
	} lb_ctrl_t;

	// taps of one window row, left tap at index 0
	function automatic coef_row_t row_coefs(input logic mode, input int unsigned row,
			input logic [ROW_REG_W-1:0] rr);
		coef_row_t rc;
		if (mode) begin
			for (int k = 0; k < TAPS; k++) begin
				rc[k] = coef_t'(rr[8*k +: 8]);
			end
		end else if (row == 1) begin
			rc[0] = coef_t'(LAP_EDGE);
			rc[1] = coef_t'(LAP_CENTER);
			rc[2] = coef_t'(LAP_EDGE);
		end else begin
			rc[0] = '0;
			rc[1] = coef_t'(LAP_EDGE);
			rc[2] = '0;
		end
		return rc;
	endfunction

endpackage

>>> src/conv3x3_laplacian_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_laplacian_filter
// 3x3 Laplacian or programmable convolution over a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and keeps up with a continuous stream: a new
// transaction is taken every cycle while the output register is empty or
// being drained. Each pixel at row r >= 2, column c >= 2 yields the result
// for centre (r-1, c-1) on the output after it passes the line store read,
// the row sums, two scaling stages and the output register in that order;
// all other pixels yield none. The throughput is one pixel per clock: each
// line store reads and writes one column per pixel and the window shifts
// once per pixel, and a stalled output holds the whole pipeline. Border
// pixels give no output. frame_start forces row 0, column 0; positions
// wrap at the configured size so frames may follow each other without
// frame_start. Line stores have no reset; they are read for every pixel,
// but only what the preceding rows of the frame wrote reaches a result.
// ----------------------------------------------------------------------------
module conv3x3_laplacian_filter import cl3_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// config port
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// pixel input
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PIX_W-1:0] pixel_in,
	input  logic             frame_start,
	// result output
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] pixel_out,
	output logic [POS_W-1:0] out_column,
	output logic [POS_W-1:0] out_row,
	output logic             frame_last
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WXW = ($clog2(MAX_WIDTH + 1) > CFG_SIZE_W) ?
		$clog2(MAX_WIDTH + 1) : CFG_SIZE_W;
	localparam int HXW = ($clog2(MAX_HEIGHT + 1) > CFG_SIZE_W) ?
		$clog2(MAX_HEIGHT + 1) : CFG_SIZE_W;

	typedef struct packed {
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic             last;
	} side_t;

	// config registers
	logic                  kernel_mode_q;
	logic [ROW_REG_W-1:0]  kernel_top_q;
	logic [ROW_REG_W-1:0]  kernel_mid_q;
	logic [ROW_REG_W-1:0]  kernel_bot_q;
	logic [CFG_SIZE_W-1:0] image_width_q;
	logic [CFG_SIZE_W-1:0] image_height_q;
	logic                  cfg_wr;
	reg_idx_t              cfg_idx;

	// position
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [WXW-1:0] w_ext;
	logic [WXW-1:0] w_eff;
	logic [HXW-1:0] h_ext;
	logic [HXW-1:0] h_eff;
	logic [CW-1:0]  c1;
	logic [RW-1:0]  r1;
	logic [CW-1:0]  c_sel;
	logic [HXW-1:0] r2;
	logic [RW-1:0]  r_sel;
	logic [WXW-1:0] cn;
	logic [HXW-1:0] rn;
	logic [CW-1:0]  col_nx;
	logic [RW-1:0]  row_nx;
	logic           produce;
	side_t          side_s0;
	logic [31:0]    cm1;
	logic [31:0]    rm1;

	// pipeline
	logic                    en;
	logic                    acc;
	logic                    v_s1;
	logic                    pv_s1;
	logic                    pv_s2;
	logic                    pv_s3;
	logic                    pv_s4;
	side_t                   side_s1;
	side_t                   side_s2;
	side_t                   side_s3;
	side_t                   side_s4;
	logic [PIX_W-1:0]        pix_s1;
	logic [CW-1:0]           c_s1;
	lb_ctrl_t                lb_ctrl;
	logic [PIX_W-1:0]        top_pix;
	logic [PIX_W-1:0]        mid_pix;
	logic [PIX_W-1:0]        col_pix [TAPS];
	logic signed [SUM_W-1:0] psum [TAPS+1];
	logic [ROW_REG_W-1:0]    row_reg [TAPS];
	logic [PIX_W-1:0]        scaled;

	// output register
	logic             out_valid_q;
	logic [PIX_W-1:0] pixel_out_q;
	side_t            side_out_q;

	// ---------------------------------------------------------------- config
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_mode_q  <= 1'b0;
			kernel_top_q   <= '0;
			kernel_mid_q   <= '0;
			kernel_bot_q   <= '0;
			image_width_q  <= CFG_SIZE_W'(WIDTH_RST);
			image_height_q <= CFG_SIZE_W'(HEIGHT_RST);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_KERNEL_MODE:   kernel_mode_q  <= pwdata[0];
				REG_KERNEL_TOP:    kernel_top_q   <= pwdata[ROW_REG_W-1:0];
				REG_KERNEL_MIDDLE: kernel_mid_q   <= pwdata[ROW_REG_W-1:0];
				REG_KERNEL_BOTTOM: kernel_bot_q   <= pwdata[ROW_REG_W-1:0];
				REG_IMAGE_WIDTH:   image_width_q  <= pwdata[CFG_SIZE_W-1:0];
				REG_IMAGE_HEIGHT:  image_height_q <= pwdata[CFG_SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (cfg_idx)
			REG_KERNEL_MODE:   prdata = 32'(kernel_mode_q);
			REG_KERNEL_TOP:    prdata = 32'(kernel_top_q);
			REG_KERNEL_MIDDLE: prdata = 32'(kernel_mid_q);
			REG_KERNEL_BOTTOM: prdata = 32'(kernel_bot_q);
			REG_IMAGE_WIDTH:   prdata = 32'(image_width_q);
			REG_IMAGE_HEIGHT:  prdata = 32'(image_height_q);
			default:           prdata = '0;
		endcase
	end

	// ------------------------------------------------------------- position
	// saturate frame size to the supported range
	always_comb begin
		w_ext = WXW'(image_width_q);
		h_ext = HXW'(image_height_q);
		if (w_ext < WXW'(MIN_SIZE)) begin
			w_eff = WXW'(MIN_SIZE);
		end else if (w_ext > WXW'(MAX_WIDTH)) begin
			w_eff = WXW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		if (h_ext < HXW'(MIN_SIZE)) begin
			h_eff = HXW'(MIN_SIZE);
		end else if (h_ext > HXW'(MAX_HEIGHT)) begin
			h_eff = HXW'(MAX_HEIGHT);
		end else begin
			h_eff = h_ext;
		end
	end

	// position of the incoming pixel and of the next one
	always_comb begin
		c1 = frame_start ? '0 : col_q;
		r1 = frame_start ? '0 : row_q;
		if (WXW'(c1) >= w_eff) begin
			c_sel = '0;
			r2    = HXW'(r1) + HXW'(1);
		end else begin
			c_sel = c1;
			r2    = HXW'(r1);
		end
		r_sel = (r2 >= h_eff) ? '0 : r2[RW-1:0];
		cn = WXW'(c_sel) + WXW'(1);
		rn = HXW'(r_sel) + HXW'(1);
		if (cn >= w_eff) begin
			col_nx = '0;
			row_nx = (rn >= h_eff) ? '0 : rn[RW-1:0];
		end else begin
			col_nx = cn[CW-1:0];
			row_nx = r_sel;
		end
		produce = (HXW'(r_sel) >= HXW'(2)) && (WXW'(c_sel) >= WXW'(2));
		cm1 = 32'(c_sel) - 32'd1;
		rm1 = 32'(r_sel) - 32'd1;
		side_s0.col  = cm1[POS_W-1:0];
		side_s0.row  = rm1[POS_W-1:0];
		side_s0.last = (HXW'(r_sel) == h_eff - HXW'(1)) && (WXW'(c_sel) == w_eff - WXW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			col_q <= col_nx;
			row_q <= row_nx;
		end
	end

	// ------------------------------------------------------------- pipeline
	// whole pipeline moves unless a result waits on a stalled output
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;
	assign acc      = in_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			pv_s1       <= 1'b0;
			pv_s2       <= 1'b0;
			pv_s3       <= 1'b0;
			pv_s4       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= acc;
			pv_s1       <= acc && produce;
			pv_s2       <= pv_s1;
			pv_s3       <= pv_s2;
			pv_s4       <= pv_s3;
			out_valid_q <= pv_s4;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1     <= side_s0;
			pix_s1      <= pixel_in;
			c_s1        <= c_sel;
			side_s2     <= side_s1;
			side_s3     <= side_s2;
			side_s4     <= side_s3;
			side_out_q  <= side_s4;
			pixel_out_q <= scaled;
		end
	end

	// line stores
	assign lb_ctrl.rd     = acc;
	assign lb_ctrl.wr_top = en && v_s1;

	cl3_line_buf #(
		.DEPTH (MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.ctrl    (lb_ctrl),
		.rd_addr (c_sel),
		.wr_addr (c_s1),
		.pix     (pixel_in),
		.top_pix (top_pix),
		.mid_pix (mid_pix)
	);

	// row cells, top to bottom, partial sum passed down the chain
	assign col_pix[0] = top_pix;
	assign col_pix[1] = mid_pix;
	assign col_pix[2] = pix_s1;
	assign row_reg[0] = kernel_top_q;
	assign row_reg[1] = kernel_mid_q;
	assign row_reg[2] = kernel_bot_q;
	assign psum[0]    = '0;

	for (genvar g = 0; g < TAPS; g++) begin : g_row
		cl3_row_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (en),
			.shift    (en && v_s1),
			.pix_in   (col_pix[g]),
			.coefs    (row_coefs(kernel_mode_q, g, row_reg[g])),
			.psum_in  (psum[g]),
			.psum_out (psum[g+1])
		);
	end

	cl3_scale u_scale (
		.clk   (clk),
		.adv   (en),
		.total (psum[TAPS]),
		.pixel (scaled)
	);

	// outputs
	assign out_valid  = out_valid_q;
	assign pixel_out  = pixel_out_q;
	assign out_column = side_out_q.col;
	assign out_row    = side_out_q.row;
	assign frame_last = side_out_q.last;

	// ----------------------------------------------------------- assertions
	// first pixel of a frame leaves the position at row 0, column 1
	a_frame_start_pos: assert property (@(posedge clk) disable iff (!arst_n)
		acc && frame_start |=> (col_q == CW'(1)) && (row_q == '0))
		else $error("position after frame start is wrong");

	// a result in the last stage reaches the output register
	a_stage_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && pv_s4 |=> out_valid)
		else $error("result lost between last stage and output");

	// a bubble at the last stage leaves the output empty after a move
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		en && !pv_s4 |=> !out_valid)
		else $error("output valid without a result in the pipeline");

endmodule

>>> src/cl3_line_buf.sv
// ----------------------------------------------------------------------------
// cl3_line_buf
// Two line stores holding the previous two rows, with registered reads.
// ----------------------------------------------------------------------------
module cl3_line_buf import cl3_pkg::*; #(
	parameter int DEPTH = MAX_WIDTH_DEF
) (
	input  logic                     clk,
	input  lb_ctrl_t                 ctrl,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [PIX_W-1:0]         pix,
	output logic [PIX_W-1:0]         top_pix,
	output logic [PIX_W-1:0]         mid_pix
);

	localparam int AW = $clog2(DEPTH);

	logic [PIX_W-1:0] top_mem [DEPTH];
	logic [PIX_W-1:0] mid_mem [DEPTH];
	logic [PIX_W-1:0] rd_top_s1;
	logic [PIX_W-1:0] rd_mid_s1;
	logic [PIX_W-1:0] byp_pix_s1;
	logic             byp_s1;

	// middle row: read old value, store incoming pixel
	always_ff @(posedge clk) begin
		if (ctrl.rd) begin
			rd_mid_s1         <= mid_mem[rd_addr];
			mid_mem[rd_addr]  <= pix;
		end
	end

	// top row: takes the middle row value of the item in stage 1
	always_ff @(posedge clk) begin
		if (ctrl.rd) begin
			rd_top_s1 <= top_mem[rd_addr];
		end
		if (ctrl.wr_top) begin
			top_mem[wr_addr] <= rd_mid_s1;
		end
	end

	// forward when a write and a read of the same column meet
	always_ff @(posedge clk) begin
		if (ctrl.rd) begin
			byp_s1     <= ctrl.wr_top && (wr_addr == AW'(rd_addr));
			byp_pix_s1 <= rd_mid_s1;
		end
	end

	assign top_pix = byp_s1 ? byp_pix_s1 : rd_top_s1;
	assign mid_pix = rd_mid_s1;

endmodule

>>> src/cl3_row_cell.sv
// ----------------------------------------------------------------------------
// cl3_row_cell
// One window row: two column taps, three products and a running sum link.
// ----------------------------------------------------------------------------
module cl3_row_cell import cl3_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    shift,
	input  logic [PIX_W-1:0]        pix_in,
	input  coef_row_t               coefs,
	input  logic signed [SUM_W-1:0] psum_in,
	output logic signed [SUM_W-1:0] psum_out
);

	logic [PIX_W-1:0]            tap0_q;
	logic [PIX_W-1:0]            tap1_q;
	logic [PIX_W-1:0]            win [TAPS];
	logic signed [PROD_W-1:0]    prod [TAPS];
	logic signed [ROW_SUM_W-1:0] row_sum;
	logic signed [ROW_SUM_W-1:0] row_sum_s2;

	// window columns c-2, c-1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap0_q <= '0;
			tap1_q <= '0;
		end else if (shift) begin
			tap0_q <= tap1_q;
			tap1_q <= pix_in;
		end
	end

	// weighted row sum
	always_comb begin
		win[0] = tap0_q;
		win[1] = tap1_q;
		win[2] = pix_in;
		row_sum = '0;
		for (int k = 0; k < TAPS; k++) begin
			prod[k] = $signed({1'b0, win[k]}) * coefs[k];
			row_sum = row_sum + ROW_SUM_W'(prod[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_sum_s2 <= row_sum;
		end
	end

	// add to the partial sum coming down the chain
	assign psum_out = psum_in + SUM_W'(row_sum_s2);

endmodule

>>> src/cl3_scale.sv
// ----------------------------------------------------------------------------
// cl3_scale
// Scales the window sum by 8/25 toward zero and adds the output offset.
// ----------------------------------------------------------------------------
module cl3_scale import cl3_pkg::*; (
	input  logic                    clk,
	input  logic                    adv,
	input  logic signed [SUM_W-1:0] total,
	output logic [PIX_W-1:0]        pixel
);

	localparam int PW = MAG_W + RECIP_W;

	logic [SUM_W-1:0] abs_val;
	logic [MAG_W-1:0] mag_s3;
	logic             neg_s3;
	logic [PW-1:0]    prod;
	logic [QUO_W-1:0] quo_s4;
	logic [MAG_W-1:0] mag_s4;
	logic             neg_s4;
	logic [MAG_W-1:0] rem;
	logic [QUO_W-1:0] quo;
	logic [PIX_W-1:0] quo8;
	logic [PIX_W-1:0] sgn8;

	// magnitude times the reduced numerator
	assign abs_val = total[SUM_W-1] ? SUM_W'(-total) : SUM_W'(total);

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s3 <= MAG_W'(abs_val) * MAG_W'(SCALE_MUL);
			neg_s3 <= total[SUM_W-1];
		end
	end

	// reciprocal estimate, low by at most one
	assign prod = PW'(mag_s3) * PW'(RECIP_MUL);

	always_ff @(posedge clk) begin
		if (adv) begin
			quo_s4 <= prod[RECIP_SHIFT +: QUO_W];
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
		end
	end

	// correct estimate, restore sign, offset and wrap to 8 bits
	always_comb begin
		rem  = mag_s4 - MAG_W'(quo_s4) * MAG_W'(SCALE_DIV);
		quo  = (rem >= MAG_W'(SCALE_DIV)) ? quo_s4 + QUO_W'(1) : quo_s4;
		quo8 = quo[PIX_W-1:0];
		sgn8 = neg_s4 ? PIX_W'(-quo8) : quo8;
		pixel = sgn8 + PIX_W'(OUT_OFFSET);
	end

endmodule

>>> verif/tb_conv3x3_laplacian_filter.sv
// ----------------------------------------------------------------------------
// tb_conv3x3_laplacian_filter
// Self-checking testbench for the 3x3 Laplacian / programmable convolution.
// ----------------------------------------------------------------------------
// Pixels are streamed in raster order through the valid/ready input while an
// in-bench filter predictor, fed from every accepted transaction, queues the
// filtered pixel, its position and the end-of-frame flag. Each result taken
// from the output is compared field by field with the oldest queued pixel.
// Directed tests cover kernel extremes, frame sequencing, mid-frame resizing,
// size saturation, a steady stream and a long output hold-off; then random
// frames with random kernels, broken frames and random stalls on both
// sides.
// ----------------------------------------------------------------------------
module tb_conv3x3_laplacian_filter import cl3_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE       = 12;       // pipeline depth plus margin
	localparam int TAIL_CYCLES  = 20;
	localparam int CYCLE_LIMIT  = 20000;
	localparam int RANDOM_ITEMS = 120;
	localparam int IDLE_PCT     = 11;

	// expected filter output for one interior pixel
	typedef struct {
		logic [PIX_W-1:0] pix;
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic             last;
	} filtered_t;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             psel        = 1'b0;
	logic             penable     = 1'b0;
	logic             pwrite      = 1'b0;
	logic [4:0]       paddr       = '0;
	logic [31:0]      pwdata      = '0;
	logic [31:0]      prdata;
	logic             pready;
	logic             in_valid    = 1'b0;
	logic             in_ready;
	logic [PIX_W-1:0] pixel_in    = '0;
	logic             frame_start = 1'b0;
	logic             out_valid;
	logic             out_ready   = 1'b0;
	logic [PIX_W-1:0] pixel_out;
	logic [POS_W-1:0] out_column;
	logic [POS_W-1:0] out_row;
	logic             frame_last;

	// predictor copy of the registers
	logic                 mode_cfg   = 1'b0;
	logic [ROW_REG_W-1:0] taps_cfg [3] = '{default: '0};
	logic [CFG_SIZE_W-1:0] width_cfg  = CFG_SIZE_W'(WIDTH_RST);
	logic [CFG_SIZE_W-1:0] height_cfg = CFG_SIZE_W'(HEIGHT_RST);

	// predictor copy of the line stores, window and position
	logic [PIX_W-1:0] store_top [MAX_WIDTH_DEF];
	logic [PIX_W-1:0] store_mid [MAX_WIDTH_DEF];
	logic [PIX_W-1:0] win_hist [3][2] = '{default: '0};
	int unsigned      col_pos = 0;
	int unsigned      row_pos = 0;

	filtered_t pending_pixels[$];
	int        mismatch_count = 0;
	int        cycle_count    = 0;
	int        rx_hold_left   = 0;
	bit        steady_tx      = 1'b0;
	bit        steady_rx      = 1'b0;

	conv3x3_laplacian_filter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_in   (pixel_in),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.out_column (out_column),
		.out_row    (out_row),
		.frame_last (frame_last)
	);

	always #CLK_HALF clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// output side: random stalls, steady stretches and long hold-offs
	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else if (steady_rx) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// compare each result transaction with the oldest predicted pixel
	always @(posedge clk) begin : check_results
		filtered_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected result: pixel_out %0d column %0d row %0d",
					pixel_out, out_column, out_row);
				mismatch_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_out !== want.pix) begin
					$error("pixel_out: expected %0d, got %0d", want.pix, pixel_out);
					mismatch_count++;
				end
				if (out_column !== want.column) begin
					$error("out_column: expected %0d, got %0d", want.column, out_column);
					mismatch_count++;
				end
				if (out_row !== want.row) begin
					$error("out_row: expected %0d, got %0d", want.row, out_row);
					mismatch_count++;
				end
				if (frame_last !== want.last) begin
					$error("frame_last: expected %0d, got %0d", want.last, frame_last);
					mismatch_count++;
				end
			end
		end
	end

	// frame size as the block uses it
	function automatic int unsigned clamp_size(input logic [CFG_SIZE_W-1:0] v,
			input int unsigned hi);
		if (32'(v) < MIN_SIZE) return MIN_SIZE;
		if (32'(v) > hi) return hi;
		return 32'(v);
	endfunction

	// kernel row with the signed extremes favored
	function automatic logic [ROW_REG_W-1:0] rand_taps();
		logic [ROW_REG_W-1:0] t;
		for (int k = 0; k < TAPS; k++) begin
			case ($urandom_range(3))
				0: t[8*k +: 8] = 8'h80;
				1: t[8*k +: 8] = 8'h7F;
				default: t[8*k +: 8] = 8'($urandom);
			endcase
		end
		return t;
	endfunction

	// advance the filter model by one accepted pixel
	task automatic filter_pixel(input logic [PIX_W-1:0] pix, input logic fs);
		int unsigned      w;
		int unsigned      h;
		int unsigned      c;
		int unsigned      r;
		int               acc;
		logic [PIX_W-1:0] win [3][3];
		filtered_t        res;
		w = clamp_size(width_cfg, MAX_WIDTH_DEF);
		h = clamp_size(height_cfg, MAX_HEIGHT_DEF);
		// position, with wrap on a shrunken size
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h) row_pos = 0;
		c = col_pos;
		r = row_pos;
		// window: two old columns plus the new column
		for (int y = 0; y < 3; y++) begin
			win[y][0] = win_hist[y][0];
			win[y][1] = win_hist[y][1];
		end
		win[0][2] = store_top[c];
		win[1][2] = store_mid[c];
		win[2][2] = pix;
		// interior centre: weighted sum, scale, offset, wrap
		if (r >= 2 && c >= 2) begin
			acc = 0;
			if (mode_cfg) begin
				for (int y = 0; y < 3; y++) begin
					for (int x = 0; x < 3; x++) begin
						acc += int'(win[y][x]) * int'(coef_t'(taps_cfg[y][8*x +: 8]));
					end
				end
			end else begin
				acc = LAP_CENTER * int'(win[1][1]) + LAP_EDGE * (int'(win[0][1])
					+ int'(win[2][1]) + int'(win[1][0]) + int'(win[1][2]));
			end
			acc = acc * SCALE_NUM / SCALE_DEN + OUT_OFFSET;
			res.pix    = acc[PIX_W-1:0];
			res.column = POS_W'(c - 1);
			res.row    = POS_W'(r - 1);
			res.last   = (r == h - 1) && (c == w - 1);
			pending_pixels.push_back(res);
		end
		// shift window, update line stores, step position
		for (int y = 0; y < 3; y++) begin
			win_hist[y][0] = win[y][1];
			win_hist[y][1] = win[y][2];
		end
		store_top[c] = store_mid[c];
		store_mid[c] = pix;
		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h) row_pos = 0;
		end
	endtask

	// one pixel transaction; valid is left high for a follow-on pixel
	task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic fs);
		if (!steady_tx) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid    <= 1'b1;
		pixel_in    <= pix;
		frame_start <= fs;
		do @(posedge clk); while (!in_ready);
		filter_pixel(pix, fs);
	endtask

	// n random pixels, frame_start on the first one if asked
	task automatic send_frame(input int unsigned n, input bit start);
		logic [PIX_W-1:0] pix;
		for (int unsigned i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: pix = '0;
				1: pix = '1;
				default: pix = PIX_W'($urandom);
			endcase
			push_pixel(pix, start && (i == 0));
		end
	endtask

	// drop valid, wait for every predicted pixel, then extra cycles
	task automatic wait_drained(input int extra);
		in_valid    <= 1'b0;
		frame_start <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	// register write: setup then access; back-to-back writes keep psel high
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_KERNEL_MODE:   mode_cfg = val[0];
			REG_KERNEL_TOP:    taps_cfg[0] = val[ROW_REG_W-1:0];
			REG_KERNEL_MIDDLE: taps_cfg[1] = val[ROW_REG_W-1:0];
			REG_KERNEL_BOTTOM: taps_cfg[2] = val[ROW_REG_W-1:0];
			REG_IMAGE_WIDTH:   width_cfg = val[CFG_SIZE_W-1:0];
			REG_IMAGE_HEIGHT:  height_cfg = val[CFG_SIZE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic release_bus();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// full register set, written once the block has gone idle
	task automatic configure(input logic mode, input logic [ROW_REG_W-1:0] top,
			input logic [ROW_REG_W-1:0] mid, input logic [ROW_REG_W-1:0] bot,
			input logic [CFG_SIZE_W-1:0] w, input logic [CFG_SIZE_W-1:0] h);
		wait_drained(SETTLE);
		write_reg(REG_KERNEL_MODE, 32'(mode));
		write_reg(REG_KERNEL_TOP, 32'(top));
		write_reg(REG_KERNEL_MIDDLE, 32'(mid));
		write_reg(REG_KERNEL_BOTTOM, 32'(bot));
		write_reg(REG_IMAGE_WIDTH, 32'(w));
		write_reg(REG_IMAGE_HEIGHT, 32'(h));
		release_bus();
	endtask

	// Laplacian on a checkerboard of 0/255: both sum extremes
	task automatic test_laplacian_extremes();
		configure(1'b0, '0, '0, '0, 5, 4);
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 5; c++) begin
				push_pixel(((r + c) % 2) ? '1 : '0, (r == 0) && (c == 0));
			end
		end
	endtask

	// configured taps: all +127, all -128, then a mixed kernel
	task automatic test_custom_kernel();
		configure(1'b1, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 3, 3);
		for (int i = 0; i < 9; i++) push_pixel('1, i == 0);
		configure(1'b1, 24'h808080, 24'h808080, 24'h808080, 3, 3);
		for (int i = 0; i < 9; i++) push_pixel('1, i == 0);
		configure(1'b1, 24'hFF0180, 24'h02807F, 24'hFE7F00, 4, 4);
		send_frame(16, 1'b1);
	endtask

	// frame restart mid-frame, then frames back to back without frame_start
	task automatic test_frame_sequencing();
		configure(1'b0, '0, '0, '0, 3, 3);
		send_frame(4, 1'b1);
		send_frame(9, 1'b1);
		send_frame(18, 1'b0);
	endtask

	// width, then height, shrunk mid-frame: position wraps
	task automatic test_resize_midframe();
		configure(1'b1, rand_taps(), rand_taps(), rand_taps(), 8, 6);
		send_frame(48, 1'b1);
		send_frame(30, 1'b0);
		wait_drained(SETTLE);
		write_reg(REG_IMAGE_WIDTH, 32'd5);
		release_bus();
		send_frame(27, 1'b0);
		wait_drained(SETTLE);
		write_reg(REG_IMAGE_HEIGHT, 32'd3);
		release_bus();
		send_frame(28, 1'b0);
	endtask

	// sizes below the minimum and above the maximum saturate
	task automatic test_size_limits();
		configure(1'b0, '0, '0, '0, 0, 2);
		send_frame(9, 1'b1);
		// oversize: the position runs on along the first saturated row
		configure(1'b1, rand_taps(), rand_taps(), rand_taps(), 2047, 2047);
		send_frame(40, 1'b1);
	endtask

	// one frame with no idling on either side
	task automatic test_steady_stream();
		configure(1'b1, rand_taps(), rand_taps(), rand_taps(), 10, 8);
		steady_tx = 1'b1;
		steady_rx = 1'b1;
		send_frame(80, 1'b1);
		steady_tx = 1'b0;
		steady_rx = 1'b0;
	endtask

	// long output hold-off fills the pipeline, then the sender pauses
	task automatic test_backpressure();
		configure(1'b1, rand_taps(), rand_taps(), rand_taps(), 6, 5);
		steady_tx = 1'b1;
		rx_hold_left = 400;
		send_frame(60, 1'b1);
		steady_tx = 1'b0;
		wait_drained(0);
		send_frame(30, 1'b0);
	endtask

	// random kernels and sizes; some frames cut short and restarted
	task automatic test_random_frames(input int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		bit          restart;
		bit          broken;
		sent = 0;
		restart = 1'b1;
		while (sent < n_items) begin
			if (restart || $urandom_range(1) == 1) begin
				configure(1'($urandom_range(1)), rand_taps(), rand_taps(), rand_taps(),
					CFG_SIZE_W'(($urandom_range(9) == 0) ? $urandom_range(13, 40) :
						$urandom_range(1, 12)),
					CFG_SIZE_W'($urandom_range(2, 8)));
			end
			steady_tx = ($urandom_range(4) == 0);
			steady_rx = ($urandom_range(4) == 0);
			len = clamp_size(width_cfg, MAX_WIDTH_DEF) * clamp_size(height_cfg, MAX_HEIGHT_DEF);
			broken = ($urandom_range(99) < 15);
			if (broken) len = $urandom_range(1, len - 1);
			// last frame is cut to the item budget
			if (len > n_items - sent) begin
				len = n_items - sent;
				broken = 1'b1;
			end
			send_frame(len, restart || ($urandom_range(3) == 0));
			restart = broken;
			sent += len;
		end
		steady_tx = 1'b0;
		steady_rx = 1'b0;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_laplacian_extremes();
		test_custom_kernel();
		test_frame_sequencing();
		test_resize_midframe();
		test_size_limits();
		test_steady_stream();
		test_backpressure();
		test_random_frames(RANDOM_ITEMS);
		wait_drained(TAIL_CYCLES);
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
